// File: rtl/lbcs_pkg.sv
// Package for the LED blink/chase sequencer: payload structs, job descriptor,
// register indexes, reset values and small helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbcs_pkg;

    localparam int CMD_W     = 2;
    localparam int AMT_W     = 16;
    localparam int COLOR_W   = 24;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int ELAPSED_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_LEDS_DEFAULT = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START_CNT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START_DUR = 2'd2;

    localparam logic KIND_BLINK = 1'b0;
    localparam logic KIND_CHASE = 1'b1;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_BLINK = 2'd1;
    localparam logic [1:0] MODE_CHASE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_B   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 2'd3;

    localparam logic [AMT_W-1:0]   INTERVAL_RST  = 16'd100;
    localparam logic [COLOR_W-1:0] COLOR_GREEN   = 24'h008000;
    localparam logic [COLOR_W-1:0] COLOR_BLACK   = 24'h000000;
    localparam logic [CNT_W-1:0]   LED_COUNT_RST = 6'd8;

    localparam logic JOB_FILL = 1'b0;
    localparam logic JOB_PAIR = 1'b1;

    localparam int JOB_Q_DEPTH = 2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             anim_kind;
        logic [AMT_W-1:0] amount;
        logic             repeat_forever;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   led_index;
        logic [COLOR_W-1:0] led_color;
        logic               last;
        logic               active;
    } out_item_t;

    typedef struct packed {
        logic [AMT_W-1:0]   interval_ticks;
        logic [COLOR_W-1:0] color_a;
        logic [COLOR_W-1:0] color_b;
        logic [CNT_W-1:0]   led_count;
    } cfg_t;

    // one run of writes for the back end
    typedef struct packed {
        logic             kind;
        logic [CNT_W-1:0] fill_count;
        logic             use_a;
        logic [IDX_W-1:0] pos_a;
        logic [IDX_W-1:0] pos_b;
        logic             clear;
        logic             active;
    } job_t;

    // LEDs in use, clamped to 1 .. max_leds
    function automatic logic [CNT_W-1:0] leds_in_use(input logic [CNT_W-1:0] cnt,
                                                     input logic [CNT_W-1:0] max_leds);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (cnt == '0)
            n = CNT_W'(1);
        else if (cnt > max_leds)
            n = max_leds;
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lbcs_front.sv
// Front end: accepts items, keeps the animation state, divides durations and
// turns each step or chase start into a job for the back end.
// Depends on lbcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbcs_front #(
    parameter int MAX_LEDS = lbcs_pkg::MAX_LEDS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire lbcs_pkg::in_item_t item,
    input  wire lbcs_pkg::cfg_t    cfg,
    input  wire logic              q_full,
    output logic                   q_push,
    output lbcs_pkg::job_t         q_job
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    localparam int AW = lbcs_pkg::AMT_W;
    localparam int CW = lbcs_pkg::CNT_W;
    localparam int BW = $clog2(AW);

    logic [2:0]                         state_reg, state_next;
    logic [1:0]                         mode_reg, mode_next;
    logic                               running_reg, running_next;
    logic [AW-1:0]                      steps_reg, steps_next;
    logic                               forever_reg, forever_next;
    logic                               phase_reg, phase_next;
    logic [lbcs_pkg::IDX_W-1:0]         pos_reg, pos_next;
    logic [lbcs_pkg::ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [AW-1:0]                      quo_reg, quo_next;
    logic [AW:0]                        rem_reg, rem_next;
    logic [BW-1:0]                      bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]                      mod_reg, mod_next;
    lbcs_pkg::job_t                     job_reg, job_next;
    logic                               pend_kind_reg, pend_kind_next;
    logic                               pend_dur_reg, pend_dur_next;
    logic                               pend_forever_reg, pend_forever_next;

    logic [CW-1:0]                      n_use;
    logic                               accept;
    logic [lbcs_pkg::ELAPSED_W-1:0]     elapsed_inc;
    logic [AW-1:0]                      steps_dec;
    logic                               ended;
    logic [AW:0]                        rem_sh;

    assign n_use  = lbcs_pkg::leds_in_use(cfg.led_count, CW'(MAX_LEDS));
    assign full   = (state_reg != S_IDLE);
    assign accept = push && !full;
    assign q_push = (state_reg == S_PUSH) && !q_full;
    assign q_job  = job_reg;

    assign elapsed_inc = elapsed_reg + lbcs_pkg::ELAPSED_W'(1);
    assign steps_dec   = (steps_reg != '0) ? steps_reg - AW'(1) : '0;
    assign ended       = (steps_dec == '0) && !forever_reg;
    assign rem_sh      = {rem_reg[AW-1:0], quo_reg[AW-1]};

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        running_next      = running_reg;
        steps_next        = steps_reg;
        forever_next      = forever_reg;
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        elapsed_next      = elapsed_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        bit_cnt_next      = bit_cnt_reg;
        mod_next          = mod_reg;
        job_next          = job_reg;
        pend_kind_next    = pend_kind_reg;
        pend_dur_next     = pend_dur_reg;
        pend_forever_next = pend_forever_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == lbcs_pkg::CMD_TICK)
                    begin
                        if (running_reg)
                        begin
                            elapsed_next = elapsed_inc;
                            if (elapsed_inc > {1'b0, cfg.interval_ticks})
                            begin
                                elapsed_next = '0;
                                phase_next   = !phase_reg;
                                steps_next   = (steps_dec == '0 && forever_reg) ? AW'(1)
                                                                                : steps_dec;
                                if (ended)
                                begin
                                    running_next = 1'b0;
                                    forever_next = 1'b0;
                                    mode_next    = lbcs_pkg::MODE_NONE;
                                end
                                job_next.clear      = ended;
                                job_next.active     = !ended;
                                job_next.fill_count = n_use;
                                job_next.use_a      = !phase_reg;
                                job_next.pos_a      = pos_reg;
                                job_next.pos_b      = pos_reg;
                                if (mode_reg == lbcs_pkg::MODE_CHASE)
                                begin
                                    job_next.kind = lbcs_pkg::JOB_PAIR;
                                    mod_next      = {1'b0, pos_reg} + CW'(1);
                                    state_next    = S_MOD;
                                end
                                else
                                begin
                                    job_next.kind = lbcs_pkg::JOB_FILL;
                                    state_next    = S_PUSH;
                                end
                            end
                        end
                    end
                    else if (item.command == lbcs_pkg::CMD_START_CNT ||
                             item.command == lbcs_pkg::CMD_START_DUR)
                    begin
                        pend_kind_next    = item.anim_kind;
                        pend_dur_next     = (item.command == lbcs_pkg::CMD_START_DUR);
                        pend_forever_next = item.repeat_forever;
                        quo_next          = item.amount;
                        if (item.command == lbcs_pkg::CMD_START_DUR &&
                            cfg.interval_ticks != '0)
                        begin
                            rem_next     = '0;
                            bit_cnt_next = BW'(AW - 1);
                            state_next   = S_DIV;
                        end
                        else
                        begin
                            state_next = S_START;
                        end
                    end
                end
            end

            // restoring divide, one quotient bit a cycle
            S_DIV:
            begin
                if (rem_sh >= {1'b0, cfg.interval_ticks})
                begin
                    rem_next = rem_sh - {1'b0, cfg.interval_ticks};
                    quo_next = {quo_reg[AW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[AW-2:0], 1'b0};
                end
                bit_cnt_next = bit_cnt_reg - BW'(1);
                if (bit_cnt_reg == '0)
                    state_next = S_START;
            end

            S_START:
            begin
                steps_next   = quo_reg;
                running_next = 1'b1;
                elapsed_next = '0;
                if (pend_kind_reg == lbcs_pkg::KIND_BLINK)
                begin
                    mode_next    = lbcs_pkg::MODE_BLINK;
                    phase_next   = 1'b1;
                    forever_next = pend_dur_reg && pend_forever_reg;
                    state_next   = S_IDLE;
                end
                else
                begin
                    mode_next           = lbcs_pkg::MODE_CHASE;
                    forever_next        = 1'b0;
                    pos_next            = '0;
                    job_next.kind       = lbcs_pkg::JOB_FILL;
                    job_next.fill_count = n_use;
                    job_next.use_a      = 1'b0;
                    job_next.pos_a      = '0;
                    job_next.pos_b      = '0;
                    job_next.clear      = 1'b0;
                    job_next.active     = 1'b1;
                    state_next          = S_PUSH;
                end
            end

            // next chase position: subtract the LED count until it fits
            S_MOD:
            begin
                if (mod_reg >= n_use)
                begin
                    mod_next = mod_reg - n_use;
                end
                else
                begin
                    pos_next       = mod_reg[lbcs_pkg::IDX_W-1:0];
                    job_next.pos_b = mod_reg[lbcs_pkg::IDX_W-1:0];
                    state_next     = S_PUSH;
                end
            end

            S_PUSH:
            begin
                if (!q_full)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= lbcs_pkg::MODE_NONE;
            running_reg <= 1'b0;
            steps_reg   <= '0;
            forever_reg <= 1'b0;
            phase_reg   <= 1'b1;
            pos_reg     <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            running_reg <= running_next;
            steps_reg   <= steps_next;
            forever_reg <= forever_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        bit_cnt_reg      <= bit_cnt_next;
        mod_reg          <= mod_next;
        job_reg          <= job_next;
        pend_kind_reg    <= pend_kind_next;
        pend_dur_reg     <= pend_dur_next;
        pend_forever_reg <= pend_forever_next;
    end

    a_fill_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_job.kind == lbcs_pkg::JOB_FILL |->
            q_job.fill_count != '0 && q_job.fill_count <= CW'(MAX_LEDS))
        else $error("fill job with LED count out of range");

    a_mod_leaves_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOD && state_next == S_PUSH |=> pos_reg < n_use[lbcs_pkg::IDX_W:0])
        else $error("chase position beyond LED count");

endmodule

`default_nettype wire

// File: rtl/lbcs_fifo.sv
// Short job queue between the front and back ends.
// Depends on lbcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbcs_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire lbcs_pkg::job_t wr_data,
    output logic                q_full,
    input  wire logic           rd,
    output lbcs_pkg::job_t      rd_data,
    output logic                q_empty
);

    localparam int DEPTH = lbcs_pkg::JOB_Q_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    lbcs_pkg::job_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_wr, do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("job queue overfilled");

endmodule

`default_nettype wire

// File: rtl/lbcs_back.sv
// Back end: expands queued jobs into single LED writes, one per cycle unless
// the receiver stalls, with a clear-to-black run for ending jobs, into a
// one-entry result register. Depends on lbcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbcs_back #(
    parameter int MAX_LEDS = lbcs_pkg::MAX_LEDS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lbcs_pkg::cfg_t cfg,
    input  wire logic           q_empty,
    input  wire lbcs_pkg::job_t q_job,
    output logic                q_pop,
    output logic                empty,
    input  wire logic           pop,
    output lbcs_pkg::out_item_t result
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_MAIN  = 2'd1;
    localparam logic [1:0] B_CLEAR = 2'd2;

    localparam int CW = lbcs_pkg::CNT_W;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    lbcs_pkg::job_t        job_reg;
    lbcs_pkg::out_item_t   res_reg, res_next;
    logic                  valid_reg, valid_next;
    logic                  load;
    logic                  main_last;

    assign load   = (state_reg != B_IDLE) && (!valid_reg || pop);
    assign q_pop  = (state_reg == B_IDLE) && !q_empty;
    assign empty  = !valid_reg;
    assign result = res_reg;

    assign main_last = (job_reg.kind == lbcs_pkg::JOB_PAIR) ? (cnt_reg == CW'(1))
                                                            : (cnt_reg == job_reg.fill_count - CW'(1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        valid_next = valid_reg;

        if (pop && valid_reg)
            valid_next = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    cnt_next   = '0;
                    state_next = B_MAIN;
                end
            end

            B_MAIN:
            begin
                if (load)
                begin
                    valid_next      = 1'b1;
                    res_next.active = job_reg.active;
                    res_next.last   = main_last && !job_reg.clear;
                    if (job_reg.kind == lbcs_pkg::JOB_PAIR)
                    begin
                        // old position back to background, then the new one lit
                        res_next.led_index = (cnt_reg == '0) ? job_reg.pos_a : job_reg.pos_b;
                        res_next.led_color = (cnt_reg == '0) ? cfg.color_b : cfg.color_a;
                    end
                    else
                    begin
                        res_next.led_index = cnt_reg[lbcs_pkg::IDX_W-1:0];
                        res_next.led_color = job_reg.use_a ? cfg.color_a : cfg.color_b;
                    end
                    cnt_next = cnt_reg + CW'(1);
                    if (main_last)
                    begin
                        cnt_next   = '0;
                        state_next = job_reg.clear ? B_CLEAR : B_IDLE;
                    end
                end
            end

            B_CLEAR:
            begin
                if (load)
                begin
                    valid_next         = 1'b1;
                    res_next.active    = job_reg.active;
                    res_next.led_index = cnt_reg[lbcs_pkg::IDX_W-1:0];
                    res_next.led_color = lbcs_pkg::COLOR_BLACK;
                    res_next.last      = (cnt_reg == CW'(MAX_LEDS - 1));
                    cnt_next           = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(MAX_LEDS - 1))
                        state_next = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        if (q_pop)
            job_reg <= q_job;
    end

    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |-> cnt_reg < CW'(MAX_LEDS))
        else $error("clear run past the strip end");

    a_clear_black: assert property (@(posedge clk) disable iff (!rst_n)
        load && state_reg == B_CLEAR |=> result.led_color == lbcs_pkg::COLOR_BLACK)
        else $error("clear write not black");

    a_clear_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        load && state_reg == B_CLEAR && cnt_reg == CW'(MAX_LEDS - 1) |=> result.last)
        else $error("final clear write not marked last");

endmodule

`default_nettype wire

// File: rtl/led_blink_chase_sequencer.sv
// LED blink/chase sequencer, top level: configuration registers, front end,
// job queue and back end. Depends on lbcs_pkg, lbcs_front, lbcs_fifo, lbcs_back.
//
// Usage
//   Items (ticks and start commands) go in on push/full: a transfer happens
//   when push is high and full is low. LED writes come out on empty/pop: the
//   oldest write sits on result while empty is low and is taken by pop.
//   Registers are written on cfg_valid/cfg_ready (ready is always high); the
//   user must write them only while the block is idle; it does not enforce this.
// Timing
//   A start by duration runs the divider in S_DIV, and full stays high
//   while it runs. A chase step searches for the next position in S_MOD by
//   repeated subtraction. The back end drives one write a cycle while the
//   receiver keeps popping, and a step gives at most 2 * MAX_LEDS writes
//   (a fill and a clear); the first write passes through the queue, the job
//   register and the result register. The two-entry job queue lets the front
//   take further items while writes are still draining; when the receiver
//   stalls the queue fills and full rises.
// Reset
//   rst_n clears the animation (nothing running) and restores the register
//   defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_chase_sequencer #(
    parameter int MAX_LEDS = lbcs_pkg::MAX_LEDS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire lbcs_pkg::in_item_t               item,
    output logic                                  empty,
    input  wire logic                             pop,
    output lbcs_pkg::out_item_t                   result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lbcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lbcs_pkg::COLOR_W-1:0]     cfg_data
);

    lbcs_pkg::cfg_t cfg_reg;
    lbcs_pkg::job_t push_job, pop_job;
    logic           q_full, q_empty, q_push, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_ticks <= lbcs_pkg::INTERVAL_RST;
            cfg_reg.color_a        <= lbcs_pkg::COLOR_GREEN;
            cfg_reg.color_b        <= lbcs_pkg::COLOR_GREEN;
            cfg_reg.led_count      <= lbcs_pkg::LED_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lbcs_pkg::CFG_INTERVAL:
                    cfg_reg.interval_ticks <= cfg_data[lbcs_pkg::AMT_W-1:0];
                lbcs_pkg::CFG_COLOR_A:
                    cfg_reg.color_a <= cfg_data;
                lbcs_pkg::CFG_COLOR_B:
                    cfg_reg.color_b <= cfg_data;
                lbcs_pkg::CFG_LED_COUNT:
                    cfg_reg.led_count <= cfg_data[lbcs_pkg::CNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    lbcs_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    lbcs_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (push_job),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_data (pop_job),
        .q_empty (q_empty)
    );

    lbcs_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: bench/led_blink_chase_sequencer_tb.sv
// Self-checking testbench for led_blink_chase_sequencer: directed table then random
// start/tick sequences, each LED write checked against the table or an in-bench predictor.
// Depends on lbcs_pkg and the RTL top level only.
`timescale 1ns / 1ps

module led_blink_chase_sequencer_tb;

    localparam int CMD_W     = lbcs_pkg::CMD_W;
    localparam int AMT_W     = lbcs_pkg::AMT_W;
    localparam int COLOR_W   = lbcs_pkg::COLOR_W;
    localparam int IDX_W     = lbcs_pkg::IDX_W;
    localparam int CNT_W     = lbcs_pkg::CNT_W;
    localparam int ELAPSED_W = lbcs_pkg::ELAPSED_W;
    localparam int CFG_IDX_W = lbcs_pkg::CFG_IDX_W;

    localparam int LED_SLOTS     = lbcs_pkg::MAX_LEDS_DEFAULT;
    localparam int SETTLE_CYCLES = 100;     // divider, chase search and queue, with margin
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 40;
    localparam longint LIMIT_NS  = 64'd10_000_000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [COLOR_W-1:0]   reg_data;
        lbcs_pkg::in_item_t   it;
        logic                 typed;       // expectation written in the table
        logic [6:0]           n_writes;
        logic [COLOR_W-1:0]   colour;
        logic                 active;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    lbcs_pkg::in_item_t   item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    lbcs_pkg::out_item_t  result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLOR_W-1:0]   cfg_data = '0;

    logic calm = 1'b0;
    logic hold_go = 1'b0;
    bit   dirty;
    int   mismatches;

    stim_row_t           offered_rows[$];
    lbcs_pkg::out_item_t led_writes_due[$];
    lbcs_pkg::out_item_t step_writes[$];

    // predictor state and register copies
    logic [AMT_W-1:0]     reg_interval  = lbcs_pkg::INTERVAL_RST;
    logic [COLOR_W-1:0]   reg_color_a   = lbcs_pkg::COLOR_GREEN;
    logic [COLOR_W-1:0]   reg_color_b   = lbcs_pkg::COLOR_GREEN;
    logic [CNT_W-1:0]     reg_led_count = lbcs_pkg::LED_COUNT_RST;
    logic [1:0]           seq_mode      = lbcs_pkg::MODE_NONE;
    logic                 seq_running   = 1'b0;
    logic [AMT_W-1:0]     seq_steps     = '0;
    logic                 seq_forever   = 1'b0;
    logic                 seq_phase     = 1'b1;
    logic [IDX_W-1:0]     seq_pos       = '0;
    logic [ELAPSED_W-1:0] seq_elapsed   = '0;

    led_blink_chase_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int leds_used();
        if (reg_led_count == '0)
            return 1;
        if (int'(reg_led_count) > LED_SLOTS)
            return LED_SLOTS;
        return int'(reg_led_count);
    endfunction

    task automatic add_write(input int idx, input logic [COLOR_W-1:0] colour);
        lbcs_pkg::out_item_t w;
        w.led_index = IDX_W'(idx);
        w.led_color = colour;
        w.last      = 1'b0;
        w.active    = 1'b0;
        step_writes.push_back(w);
    endtask

    task automatic advance_animation();
        int n;
        int i;
        n = leds_used();
        seq_phase = ~seq_phase;
        if (seq_mode == lbcs_pkg::MODE_BLINK)
        begin
            for (i = 0; i < n; i++)
                add_write(i, seq_phase ? reg_color_a : reg_color_b);
        end
        else if (seq_mode == lbcs_pkg::MODE_CHASE)
        begin
            add_write(int'(seq_pos), reg_color_b);
            seq_pos = IDX_W'((int'(seq_pos) + 1) % n);
            add_write(int'(seq_pos), reg_color_a);
        end
        if (seq_steps != '0)
            seq_steps--;
        if (seq_steps == '0 && seq_forever)
            seq_steps = AMT_W'(1);
        if (seq_steps == '0)
        begin
            seq_running = 1'b0;
            seq_forever = 1'b0;
            seq_mode    = lbcs_pkg::MODE_NONE;
            for (i = 0; i < LED_SLOTS; i++)
                add_write(i, lbcs_pkg::COLOR_BLACK);
        end
    endtask

    // writes caused by one accepted item, left in step_writes
    task automatic predict_led_writes(input lbcs_pkg::in_item_t it);
        logic [AMT_W-1:0]    count;
        lbcs_pkg::out_item_t w;
        int                  i;
        int                  n;
        step_writes.delete();
        case (it.command)
            lbcs_pkg::CMD_TICK:
            begin
                if (seq_running)
                begin
                    seq_elapsed = seq_elapsed + 1'b1;
                    if (seq_elapsed > {1'b0, reg_interval})
                    begin
                        seq_elapsed = '0;
                        advance_animation();
                    end
                end
            end
            lbcs_pkg::CMD_START_CNT, lbcs_pkg::CMD_START_DUR:
            begin
                count = it.amount;
                if (it.command == lbcs_pkg::CMD_START_DUR && reg_interval != '0)
                    count = it.amount / reg_interval;
                seq_steps   = count;
                seq_running = 1'b1;
                seq_elapsed = '0;
                if (it.anim_kind == lbcs_pkg::KIND_BLINK)
                begin
                    seq_mode    = lbcs_pkg::MODE_BLINK;
                    seq_phase   = 1'b1;
                    seq_forever = (it.command == lbcs_pkg::CMD_START_DUR) ? it.repeat_forever
                                                                          : 1'b0;
                end
                else
                begin
                    seq_mode    = lbcs_pkg::MODE_CHASE;
                    seq_forever = 1'b0;
                    seq_pos     = '0;
                    n = leds_used();
                    for (i = 0; i < n; i++)
                        add_write(i, reg_color_b);
                end
            end
            default: ;
        endcase
        for (i = 0; i < step_writes.size(); i++)
        begin
            w        = step_writes[i];
            w.last   = (i == step_writes.size() - 1);
            w.active = seq_running;
            step_writes[i] = w;
        end
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] data);
        case (idx)
            lbcs_pkg::CFG_INTERVAL:  reg_interval  = data[AMT_W-1:0];
            lbcs_pkg::CFG_COLOR_A:   reg_color_a   = data;
            lbcs_pkg::CFG_COLOR_B:   reg_color_b   = data;
            lbcs_pkg::CFG_LED_COUNT: reg_led_count = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_write(input lbcs_pkg::out_item_t got);
        lbcs_pkg::out_item_t want;
        if (led_writes_due.size() == 0)
        begin
            report_mismatch($sformatf("write idx %0d colour %06h with nothing due",
                                      got.led_index, got.led_color));
            return;
        end
        want = led_writes_due.pop_front();
        if (got.led_index != want.led_index)
            report_mismatch($sformatf("led_index %0d, want %0d", got.led_index, want.led_index));
        if (got.led_color != want.led_color)
            report_mismatch($sformatf("led_color %06h, want %06h (idx %0d)",
                                      got.led_color, want.led_color, want.led_index));
        if (got.last != want.last)
            report_mismatch($sformatf("last %0b, want %0b (idx %0d)",
                                      got.last, want.last, want.led_index));
        if (got.active != want.active)
            report_mismatch($sformatf("active %0b, want %0b (idx %0d)",
                                      got.active, want.active, want.led_index));
    endtask

    // transfers seen at each edge: register writes, items, LED writes
    always @(posedge clk)
    begin : monitor
        stim_row_t           acc_row;
        lbcs_pkg::out_item_t w;
        int                  k;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (push && !full)
            begin
                acc_row = '0;
                if (offered_rows.size() != 0)
                    acc_row = offered_rows.pop_front();
                predict_led_writes(item);
                if (acc_row.typed)
                begin
                    for (k = 0; k < int'(acc_row.n_writes); k++)
                    begin
                        w.led_index = IDX_W'(k);
                        w.led_color = acc_row.colour;
                        w.last      = (k == int'(acc_row.n_writes) - 1);
                        w.active    = acc_row.active;
                        led_writes_due.push_back(w);
                    end
                end
                else
                begin
                    foreach (step_writes[k])
                        led_writes_due.push_back(step_writes[k]);
                end
            end
            if (pop && !empty)
                check_write(result);
        end
    end

    always @(posedge clk)
    begin : receiver
        int  hold_left;
        bit  hold_done;
        if (hold_left != 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
            pop <= calm || ($urandom_range(99) >= 9);
    end

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [COLOR_W-1:0] data);
        stim_row_t r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [CMD_W-1:0] cmd, input logic kind,
                                           input logic [AMT_W-1:0] amt, input logic fv);
        stim_row_t r;
        r                   = '0;
        r.it.command        = cmd;
        r.it.anim_kind      = kind;
        r.it.amount         = amt;
        r.it.repeat_forever = fv;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [CMD_W-1:0] cmd, input logic kind,
                                            input logic [AMT_W-1:0] amt, input logic fv,
                                            input int n, input logic [COLOR_W-1:0] colour,
                                            input logic act);
        stim_row_t r;
        r          = item_row(cmd, kind, amt, fv);
        r.typed    = 1'b1;
        r.n_writes = 7'(n);
        r.colour   = colour;
        r.active   = act;
        return r;
    endfunction

    task automatic offer(input stim_row_t r);
        cfg_valid <= 1'b0;
        if (!calm && $urandom_range(99) < 9)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        offered_rows.push_back(r);
        push <= 1'b1;
        item <= r.it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        dirty = 1'b1;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        @(posedge clk);
        while (offered_rows.size() != 0 || led_writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        dirty = 1'b0;
    endtask

    function automatic lbcs_pkg::in_item_t random_tick();
        lbcs_pkg::in_item_t it;
        it.command        = lbcs_pkg::CMD_TICK;
        it.anim_kind      = 1'($urandom_range(1));
        it.amount         = AMT_W'($urandom);
        it.repeat_forever = 1'($urandom_range(1));
        return it;
    endfunction

    initial
    begin : stimulus
        stim_row_t          plan[$];
        stim_row_t          r;
        lbcs_pkg::in_item_t it;
        int                 k;
        int                 p;
        int                 n_sent;
        int                 n_ticks;
        int                 scale;
        logic [AMT_W-1:0]   ivl;
        logic [CNT_W-1:0]   cnt;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; register defaults first: 100 ticks, green, 8 LEDs
        plan.push_back(typed_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(typed_row(CMD_UNUSED, lbcs_pkg::KIND_CHASE, 16'hFFFF, 1'b1,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(typed_row(lbcs_pkg::CMD_START_CNT, lbcs_pkg::KIND_CHASE, 16'd2, 1'b0,
                                 8, lbcs_pkg::COLOR_GREEN, 1'b1));
        plan.push_back(typed_row(lbcs_pkg::CMD_START_DUR, lbcs_pkg::KIND_BLINK, 16'd250, 1'b0,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(typed_row(CMD_UNUSED, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(typed_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(cfg_row(lbcs_pkg::CFG_INTERVAL, 24'h000000));
        plan.push_back(cfg_row(lbcs_pkg::CFG_COLOR_A, 24'hFFFFFF));
        plan.push_back(cfg_row(lbcs_pkg::CFG_COLOR_B, 24'h000000));
        plan.push_back(cfg_row(lbcs_pkg::CFG_LED_COUNT, 24'h000020));
        plan.push_back(item_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0));
        plan.push_back(item_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0));
        plan.push_back(typed_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        // zero count with forever: keeps stepping
        plan.push_back(typed_row(lbcs_pkg::CMD_START_DUR, lbcs_pkg::KIND_BLINK, 16'd0, 1'b1,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(item_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0));
        plan.push_back(item_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0));
        plan.push_back(typed_row(lbcs_pkg::CMD_START_CNT, lbcs_pkg::KIND_CHASE, 16'd0, 1'b0,
                                 32, 24'h000000, 1'b1));
        plan.push_back(item_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0));
        plan.push_back(typed_row(lbcs_pkg::CMD_START_CNT, lbcs_pkg::KIND_CHASE, 16'hFFFF, 1'b1,
                                 32, 24'h000000, 1'b1));
        plan.push_back(item_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_CHASE, 16'd0, 1'b0));
        plan.push_back(item_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_CHASE, 16'd0, 1'b0));
        plan.push_back(typed_row(lbcs_pkg::CMD_START_DUR, lbcs_pkg::KIND_CHASE, 16'hFFFF, 1'b1,
                                 32, 24'h000000, 1'b1));
        plan.push_back(typed_row(lbcs_pkg::CMD_START_CNT, lbcs_pkg::KIND_BLINK, 16'd1, 1'b1,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(item_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0));
        // upper data bits beyond the register width are dropped
        plan.push_back(cfg_row(lbcs_pkg::CFG_INTERVAL, 24'h5AFFFF));
        plan.push_back(cfg_row(lbcs_pkg::CFG_COLOR_A, 24'h000000));
        plan.push_back(cfg_row(lbcs_pkg::CFG_COLOR_B, 24'hFFFFFF));
        plan.push_back(cfg_row(lbcs_pkg::CFG_LED_COUNT, 24'hFFFFC0));
        plan.push_back(typed_row(lbcs_pkg::CMD_START_DUR, lbcs_pkg::KIND_CHASE, 16'hFFFE, 1'b0,
                                 1, 24'hFFFFFF, 1'b1));
        plan.push_back(typed_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(typed_row(lbcs_pkg::CMD_START_DUR, lbcs_pkg::KIND_BLINK, 16'hFFFF, 1'b0,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));
        plan.push_back(typed_row(lbcs_pkg::CMD_TICK, lbcs_pkg::KIND_BLINK, 16'd0, 1'b0,
                                 0, lbcs_pkg::COLOR_BLACK, 1'b0));

        for (k = 0; k < plan.size(); k++)
        begin
            r = plan[k];
            if (r.is_cfg)
            begin
                if (dirty)
                    drain_and_settle();
                write_register(r.reg_idx, r.reg_data);
            end
            else
                offer(r);
        end

        // random phases: short intervals so steps come often
        for (p = 0; p < 5; p++)
        begin
            drain_and_settle();
            case (p)
                0: begin ivl = 16'd1; cnt = 6'd63; end
                1: begin ivl = 16'd0; cnt = 6'd0;  end
                2: begin ivl = 16'd2; cnt = CNT_W'($urandom_range(1, LED_SLOTS)); end
                3: begin ivl = AMT_W'($urandom_range(0, 3)); cnt = CNT_W'($urandom); end
                default:
                begin
                    ivl = AMT_W'($urandom_range(0, 3));
                    cnt = CNT_W'($urandom_range(1, 8));
                end
            endcase
            write_register(lbcs_pkg::CFG_INTERVAL, {8'($urandom), ivl});
            write_register(lbcs_pkg::CFG_COLOR_A, COLOR_W'($urandom));
            write_register(lbcs_pkg::CFG_COLOR_B, COLOR_W'($urandom));
            write_register(lbcs_pkg::CFG_LED_COUNT, {18'($urandom), cnt});
            calm    <= (p == 1);
            hold_go <= (p == 2);
            n_sent = 0;
            while (n_sent < 36)
            begin
                if ($urandom_range(99) < 10)
                begin
                    // noise: unused code, or a tick that may land while idle
                    it = random_tick();
                    if ($urandom_range(1) == 1)
                        it.command = CMD_UNUSED;
                    r    = '0;
                    r.it = it;
                    offer(r);
                end
                else
                begin
                    it.command        = ($urandom_range(1) == 1) ? lbcs_pkg::CMD_START_DUR
                                                                 : lbcs_pkg::CMD_START_CNT;
                    it.anim_kind      = 1'($urandom_range(1));
                    it.repeat_forever = 1'($urandom_range(1));
                    scale = 1;
                    if (it.command == lbcs_pkg::CMD_START_DUR && reg_interval != '0)
                        scale = int'(reg_interval);
                    if ($urandom_range(99) < 75)
                        it.amount = AMT_W'($urandom_range(0, 5 * scale));
                    else
                        it.amount = AMT_W'($urandom);
                    r    = '0;
                    r.it = it;
                    offer(r);
                    n_sent++;
                    n_ticks = $urandom_range(0, 14);
                    for (k = 0; k < n_ticks; k++)
                    begin
                        r    = '0;
                        r.it = random_tick();
                        offer(r);
                        n_sent++;
                    end
                end
            end
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("led_blink_chase_sequencer_tb: PASS");
        else
            $display("led_blink_chase_sequencer_tb: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("led_blink_chase_sequencer_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/lbcs_pkg.sv
rtl/lbcs_front.sv
rtl/lbcs_fifo.sv
rtl/lbcs_back.sv
rtl/led_blink_chase_sequencer.sv
bench/led_blink_chase_sequencer_tb.sv
